FILE: rtl/lcs_length_engine_defines.svh
// assertion macros for the lcs length engine
`ifndef LCS_LENGTH_ENGINE_DEFINES_SVH
`define LCS_LENGTH_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LCSE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("lcs_length_engine assertion failed");
`define LCSE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lcs_length_engine implication failed");
`else
`define LCSE_ASSERT(lbl, prop)
`define LCSE_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

FILE: rtl/lcse_pkg.sv
// shared constants and types of the lcs length engine
package lcse_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int SYM_W     = 8;
    localparam int SEC_W     = 16;
    localparam int PCT_W     = 8;
    localparam int SCALE_W   = 7;
    localparam int PROD_W    = SEC_W + PCT_W;
    localparam int PCT_SCALE = 100;

    localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

    // input item kinds
    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_SECOND = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // chain token operations
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_SWEEP  = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_LENGTH  = 2'd0;
    localparam logic [1:0] REG_MIN_PERCENT = 2'd1;

    typedef struct packed {
        logic [1:0]       op;
        logic [SYM_W-1:0] sym;
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] diag;
    } token_t;

    typedef struct packed {
        logic [CNT_W-1:0] first_count;
        logic [SEC_W-1:0] second_count;
        logic             overflow;
    } fin_info_t;

endpackage

FILE: rtl/lcse_cell.sv
// one cell of the dp chain: holds one first-string char and its row entry
module lcse_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  lcse_pkg::token_t tok_in,
    output lcse_pkg::token_t tok_out
);
    import lcse_pkg::*;

    logic [SYM_W-1:0] ch_reg, ch_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic             valid_reg, valid_next;
    token_t           tok_reg, tok_next;
    logic [CNT_W-1:0] best;

    assign best = (tok_in.left > row_reg) ? tok_in.left : row_reg;

    always_comb begin
        tok_next   = tok_in;
        ch_next    = ch_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        unique case (tok_in.op)
            OP_LOAD: begin
                // first free cell takes the char
                if (!valid_reg) begin
                    ch_next     = tok_in.sym;
                    row_next    = '0;
                    valid_next  = 1'b1;
                    tok_next.op = OP_NONE;
                end
            end
            OP_SWEEP: begin
                if (valid_reg) begin
                    if (ch_reg == tok_in.sym) begin
                        row_next = tok_in.diag + CNT_W'(1);
                    end else begin
                        row_next = best;
                    end
                    tok_next.left = row_next;
                    tok_next.diag = row_reg;
                end
            end
            OP_FINISH: begin
                // carry the row entry onward and clear behind the wave
                if (valid_reg) begin
                    tok_next.left = row_reg;
                    row_next      = '0;
                    valid_next    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg  <= ch_next;
        row_reg <= row_next;
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/lcse_chain.sv
// row of dp cells, one token hop per cycle
module lcse_chain (
    input  logic             aclk,
    input  logic             aresetn,
    input  lcse_pkg::token_t tok_in,
    output lcse_pkg::token_t tok_out
);
    import lcse_pkg::*;

    token_t link [0:MAX_LEN];

    assign link[0] = tok_in;

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        lcse_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (link[i]),
            .tok_out (link[i+1])
        );
    end

    assign tok_out = link[MAX_LEN];

endmodule

FILE: rtl/lcse_result.sv
// threshold check and output register for the finish result
module lcse_result (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       exit_valid,
    input  logic [lcse_pkg::CNT_W-1:0] exit_lcs,
    input  lcse_pkg::fin_info_t        info,
    input  logic [lcse_pkg::CNT_W-1:0] min_length,
    input  logic [lcse_pkg::PCT_W-1:0] min_percent,
    output logic                       moved,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lcse_pkg::CNT_W-1:0] m_lcs_length,
    output logic [lcse_pkg::CNT_W-1:0] m_first_length,
    output logic [lcse_pkg::SEC_W-1:0] m_second_length,
    output logic                       m_is_match,
    output logic                       m_overflowed
);
    import lcse_pkg::*;

    logic              s1_valid_reg;
    logic [CNT_W-1:0]  s1_lcs_reg;
    fin_info_t         s1_info_reg;
    logic [PROD_W-1:0] s1_scaled_reg;
    logic [PROD_W-1:0] s1_pfirst_reg;
    logic [PROD_W-1:0] s1_psecond_reg;

    logic              m_valid_reg;
    logic [CNT_W-1:0]  m_lcs_reg;
    logic [CNT_W-1:0]  m_first_reg;
    logic [SEC_W-1:0]  m_second_reg;
    logic              m_match_reg;
    logic              m_ovf_reg;

    logic              match;

    assign moved = s1_valid_reg && (!m_valid_reg || m_ready);

    // exact percentage test: lcs * 100 >= percent * length, empty never meets
    assign match = (s1_lcs_reg >= min_length) &&
                   (((s1_info_reg.first_count != '0) && (s1_scaled_reg >= s1_pfirst_reg)) ||
                    ((s1_info_reg.second_count != '0) && (s1_scaled_reg >= s1_psecond_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (exit_valid) begin
                s1_valid_reg <= 1'b1;
            end else if (moved) begin
                s1_valid_reg <= 1'b0;
            end
            if (moved) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // operands widened first so the products keep their upper bits
    always_ff @(posedge aclk) begin
        if (exit_valid) begin
            s1_lcs_reg     <= exit_lcs;
            s1_info_reg    <= info;
            s1_scaled_reg  <= PROD_W'(exit_lcs) * PROD_W'(PCT_SCALE);
            s1_pfirst_reg  <= PROD_W'(min_percent) * PROD_W'(info.first_count);
            s1_psecond_reg <= PROD_W'(min_percent) * PROD_W'(info.second_count);
        end
        if (moved) begin
            m_lcs_reg    <= s1_lcs_reg;
            m_first_reg  <= s1_info_reg.first_count;
            m_second_reg <= s1_info_reg.second_count;
            m_match_reg  <= match;
            m_ovf_reg    <= s1_info_reg.overflow;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_lcs_length    = m_lcs_reg;
    assign m_first_length  = m_first_reg;
    assign m_second_length = m_second_reg;
    assign m_is_match      = m_match_reg;
    assign m_overflowed    = m_ovf_reg;

endmodule

FILE: rtl/lcs_length_engine.sv
// lcs length engine: first/second chars are accepted back to back while s_ready is high.
// a finish result reaches m_valid once the finish token has crossed the MAX_LEN-cell chain
// one cell per cycle and then passed the check stage and the output register.
// s_ready stays low from a finish transfer until its result sits in the output register.
// reset (synchronous, active low) clears cell valid bits, counters, thresholds and
// handshake state at once; no clearing pass.
`include "lcs_length_engine_defines.svh"

module lcs_length_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_kind,
    input  logic [lcse_pkg::SYM_W-1:0] s_symbol,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lcse_pkg::CNT_W-1:0] m_lcs_length,
    output logic [lcse_pkg::CNT_W-1:0] m_first_length,
    output logic [lcse_pkg::SEC_W-1:0] m_second_length,
    output logic                       m_is_match,
    output logic                       m_overflowed,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [lcse_pkg::CNT_W-1:0] cfg_data
);
    import lcse_pkg::*;

    logic [CNT_W-1:0] min_length_reg;
    logic [PCT_W-1:0] min_percent_reg;
    logic [CNT_W-1:0] first_count_reg;
    logic [SEC_W-1:0] second_count_reg;
    logic             overflow_reg;
    logic             busy_reg;
    fin_info_t        info_reg;

    logic             s_acc;
    logic             fin_acc;
    logic             cfg_acc;
    logic             first_full;
    logic             moved;
    logic             exit_fin;
    token_t           inj_tok;
    token_t           exit_tok;

    assign s_ready    = !busy_reg;
    assign cfg_ready  = 1'b1;
    assign s_acc      = s_valid && s_ready;
    assign cfg_acc    = cfg_valid && cfg_ready;
    assign fin_acc    = s_acc && (s_kind == KIND_FINISH);
    assign first_full = (first_count_reg == CNT_W'(MAX_LEN));

    always_comb begin
        inj_tok.op   = OP_NONE;
        inj_tok.sym  = s_symbol;
        inj_tok.left = '0;
        inj_tok.diag = '0;
        if (s_acc) begin
            case (s_kind)
                KIND_FIRST: begin
                    // late chars are dropped, extra chars only flag overflow
                    if (second_count_reg == '0 && !first_full) begin
                        inj_tok.op = OP_LOAD;
                    end
                end
                KIND_SECOND: inj_tok.op = OP_SWEEP;
                KIND_FINISH: inj_tok.op = OP_FINISH;
                default:     inj_tok.op = OP_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg  <= '0;
            min_percent_reg <= '0;
        end else if (cfg_acc) begin
            unique case (cfg_index)
                REG_MIN_LENGTH:  min_length_reg  <= cfg_data;
                REG_MIN_PERCENT: min_percent_reg <= cfg_data[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            busy_reg         <= 1'b0;
        end else begin
            if (fin_acc) begin
                first_count_reg  <= '0;
                second_count_reg <= '0;
                overflow_reg     <= 1'b0;
            end else if (s_acc && s_kind == KIND_FIRST && second_count_reg == '0) begin
                if (first_full) begin
                    overflow_reg <= 1'b1;
                end else begin
                    first_count_reg <= first_count_reg + CNT_W'(1);
                end
            end else if (s_acc && s_kind == KIND_SECOND && second_count_reg != SEC_MAX) begin
                second_count_reg <= second_count_reg + SEC_W'(1);
            end
            if (fin_acc) begin
                busy_reg <= 1'b1;
            end else if (moved) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_acc) begin
            info_reg.first_count  <= first_count_reg;
            info_reg.second_count <= second_count_reg;
            info_reg.overflow     <= overflow_reg;
        end
    end

    lcse_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tok_in  (inj_tok),
        .tok_out (exit_tok)
    );

    assign exit_fin = (exit_tok.op == OP_FINISH);

    lcse_result u_result (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .exit_valid      (exit_fin),
        .exit_lcs        (exit_tok.left),
        .info            (info_reg),
        .min_length      (min_length_reg),
        .min_percent     (min_percent_reg),
        .moved           (moved),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lcs_length    (m_lcs_length),
        .m_first_length  (m_first_length),
        .m_second_length (m_second_length),
        .m_is_match      (m_is_match),
        .m_overflowed    (m_overflowed)
    );

    `LCSE_ASSERT_IMPL(a_exit_while_busy, exit_fin, busy_reg)
    `LCSE_ASSERT(a_count_range, first_count_reg <= CNT_W'(MAX_LEN))
    `LCSE_ASSERT_IMPL(a_overflow_full, overflow_reg, first_full)
    `LCSE_ASSERT(a_late_first_held, (second_count_reg != '0 && !fin_acc) |=> first_count_reg == $past(first_count_reg))

endmodule

FILE: test/lcs_checker.sv
// checker for the lcs length engine: watches all channels, predicts finish results, compares
`timescale 1ns / 100ps

module lcs_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [1:0]                 s_kind,
    input  logic [lcse_pkg::SYM_W-1:0] s_symbol,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [lcse_pkg::CNT_W-1:0] m_lcs_length,
    input  logic [lcse_pkg::CNT_W-1:0] m_first_length,
    input  logic [lcse_pkg::SEC_W-1:0] m_second_length,
    input  logic                       m_is_match,
    input  logic                       m_overflowed,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [lcse_pkg::CNT_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);
    import lcse_pkg::*;

    typedef struct {
        logic [CNT_W-1:0] lcs;
        logic [CNT_W-1:0] first_len;
        logic [SEC_W-1:0] second_len;
        logic             match;
        logic             ovf;
    } lcs_result_t;

    lcs_result_t      expected_results[$];
    logic [SYM_W-1:0] stored_chars[MAX_LEN];
    logic [CNT_W-1:0] lcs_row[MAX_LEN+1];
    int unsigned      first_kept;
    int unsigned      second_seen;
    bit               overflow_seen;
    logic [CNT_W-1:0] min_len_reg;
    logic [PCT_W-1:0] min_pct_reg;
    int               errors = 0;

    function automatic void clear_store();
        for (int i = 0; i < MAX_LEN; i++) stored_chars[i] = '0;
        for (int i = 0; i <= MAX_LEN; i++) lcs_row[i] = '0;
        first_kept    = 0;
        second_seen   = 0;
        overflow_seen = 1'b0;
    endfunction

    // one pass of the recurrence over the kept first string
    function automatic void sweep_row(input logic [SYM_W-1:0] c);
        logic [CNT_W-1:0] diag;
        logic [CNT_W-1:0] above;
        diag = lcs_row[0];
        for (int i = 1; i <= first_kept; i++) begin
            above = lcs_row[i];
            if (stored_chars[i-1] == c) begin
                lcs_row[i] = diag + 1'b1;
            end else begin
                lcs_row[i] = (lcs_row[i-1] > above) ? lcs_row[i-1] : above;
            end
            diag = above;
        end
    endfunction

    function automatic bit percent_met(input int unsigned lcs, input int unsigned len);
        longint unsigned lhs;
        longint unsigned rhs;
        if (len == 0) return 1'b0;
        lhs = longint'(lcs) * PCT_SCALE;
        rhs = longint'(min_pct_reg) * len;
        return lhs >= rhs;
    endfunction

    task automatic absorb(input logic [1:0] kind, input logic [SYM_W-1:0] sym);
        lcs_result_t res;
        case (kind)
            KIND_FIRST: begin
                // late first chars are dropped without touching the overflow flag
                if (second_seen == 0) begin
                    if (first_kept < MAX_LEN) begin
                        stored_chars[first_kept] = sym;
                        first_kept++;
                    end else begin
                        overflow_seen = 1'b1;
                    end
                end
            end
            KIND_SECOND: begin
                sweep_row(sym);
                if (second_seen < SEC_MAX) second_seen++;
            end
            KIND_FINISH: begin
                res.lcs        = lcs_row[first_kept];
                res.first_len  = CNT_W'(first_kept);
                res.second_len = SEC_W'(second_seen);
                res.match      = (res.lcs >= min_len_reg) &&
                                 (percent_met(res.lcs, first_kept) ||
                                  percent_met(res.lcs, second_seen));
                res.ovf        = overflow_seen;
                expected_results.push_back(res);
                clear_store();
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned exp,
                               input int unsigned act);
        if (exp != act) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : watch
        lcs_result_t res;
        if (!aresetn) begin
            clear_store();
            min_len_reg = '0;
            min_pct_reg = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_LENGTH:  min_len_reg = cfg_data;
                    REG_MIN_PERCENT: min_pct_reg = cfg_data[PCT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, lcs_length %0d",
                             $time, m_lcs_length);
                    errors++;
                end else begin
                    res = expected_results.pop_front();
                    check_field("lcs_length", res.lcs, m_lcs_length);
                    check_field("first_length", res.first_len, m_first_length);
                    check_field("second_length", res.second_len, m_second_length);
                    check_field("is_match", res.match, m_is_match);
                    check_field("overflowed", res.ovf, m_overflowed);
                end
            end
            if (s_valid && s_ready) absorb(s_kind, s_symbol);
        end
        fail_count <= errors;
        pending    <= expected_results.size();
    end

endmodule

FILE: test/testbench.sv
// top of the lcs length engine testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 100ps

module testbench;
    import lcse_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int LATENCY   = MAX_LEN + 16;
    localparam int LONG_HOLD = 5000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_kind;
    logic [SYM_W-1:0] s_symbol;
    logic             m_valid;
    logic             m_ready;
    logic [CNT_W-1:0] m_lcs_length;
    logic [CNT_W-1:0] m_first_length;
    logic [SEC_W-1:0] m_second_length;
    logic             m_is_match;
    logic             m_overflowed;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [CNT_W-1:0] cfg_data;
    int               fail_count;
    int               pending;

    int               hold_requests = 0;
    bit               idle_on = 1'b1;
    bit               in_second = 1'b0;
    int               items_sent = 0;
    int               finishes = 0;

    lcs_length_engine dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_symbol        (s_symbol),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lcs_length    (m_lcs_length),
        .m_first_length  (m_first_length),
        .m_second_length (m_second_length),
        .m_is_match      (m_is_match),
        .m_overflowed    (m_overflowed),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    lcs_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_symbol        (s_symbol),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lcs_length    (m_lcs_length),
        .m_first_length  (m_first_length),
        .m_second_length (m_second_length),
        .m_is_match      (m_is_match),
        .m_overflowed    (m_overflowed),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int pick_alphabet();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return 4;
            default: return 16;
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol(input int alpha);
        if (alpha == 0) return SYM_W'($urandom_range(0, 255));
        return SYM_W'(8'h41 + $urandom_range(0, alpha - 1));
    endfunction

    function automatic int short_len();
        if ($urandom_range(0, 9) == 0) return 0;
        return $urandom_range(1, 12);
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [SYM_W-1:0] sym);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_kind   <= kind;
        s_symbol <= sym;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (kind == KIND_SECOND || kind == KIND_FINISH || (kind == KIND_FIRST && !in_second))
            items_sent++;
        if (kind == KIND_SECOND) in_second = 1'b1;
        if (kind == KIND_FINISH) begin
            in_second = 1'b0;
            finishes++;
        end
    endtask

    task automatic send_sequence(input int n_first, input int n_second, input int alpha,
                                 input bit noisy);
        for (int i = 0; i < n_first; i++) begin
            send_item(KIND_FIRST, pick_symbol(alpha));
            if (noisy && $urandom_range(0, 7) == 0)
                send_item(KIND_UNUSED, SYM_W'($urandom_range(0, 255)));
        end
        for (int i = 0; i < n_second; i++) begin
            send_item(KIND_SECOND, pick_symbol(alpha));
            if (noisy && $urandom_range(0, 5) == 0) send_item(KIND_FIRST, pick_symbol(alpha));
        end
        send_item(KIND_FINISH, SYM_W'($urandom_range(0, 255)));
    endtask

    // checker updates pending through a register after a transfer, hence the leading edge
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic configure(input logic [CNT_W-1:0] len_thr, input logic [PCT_W-1:0] pct_thr);
        wait_drained();
        repeat (LATENCY) @(posedge aclk);
        write_reg(REG_MIN_LENGTH, len_thr);
        write_reg(REG_MIN_PERCENT, CNT_W'(pct_thr));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_sequence();
        int pick;
        idle_on = ($urandom_range(0, 4) != 0);
        pick    = $urandom_range(0, 19);
        if (pick < 14) begin
            send_sequence(short_len(), short_len(), pick_alphabet(), pick >= 11);
        end else if (pick < 16) begin
            send_sequence($urandom_range(13, 60), $urandom_range(13, 60), pick_alphabet(), 1'b0);
        end else if (pick == 16) begin
            send_sequence(short_len(), 0, 0, 1'b0);
        end else if (pick == 17) begin
            send_sequence(0, short_len(), 0, 1'b0);
        end else if (pick == 18) begin
            send_item(KIND_UNUSED, SYM_W'($urandom_range(0, 255)));
            send_item(KIND_FINISH, SYM_W'($urandom_range(0, 255)));
        end else begin
            // sender pause until everything in flight has come out
            wait_drained();
            send_sequence(short_len(), short_len(), pick_alphabet(), 1'b1);
        end
    endtask

    initial begin : receiver
        int stall;
        int quiet_left;
        int holds_done;
        m_ready    = 1'b0;
        quiet_left = 0;
        holds_done = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_requests != holds_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else if (quiet_left > 0) begin
                quiet_left--;
            end else if ($urandom_range(0, 199) == 0) begin
                quiet_left = $urandom_range(50, 400);
            end else if ($urandom_range(0, 5) == 0) begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        int phase_items;
        int phase_done;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_kind    = KIND_FIRST;
        s_symbol  = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_LENGTH;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        configure('0, '0);

        // empty strings and an unused kind
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_UNUSED, 8'hFF);
        send_item(KIND_FINISH, 8'hFF);
        // late first char in the middle of the second string, then a second-only and a first-only string
        send_item(KIND_FIRST, 8'h00);
        send_item(KIND_FIRST, 8'hFF);
        send_item(KIND_FIRST, 8'hAA);
        send_item(KIND_SECOND, 8'hFF);
        send_item(KIND_SECOND, 8'h00);
        send_item(KIND_FIRST, 8'h55);
        send_item(KIND_UNUSED, 8'h00);
        send_item(KIND_SECOND, 8'h55);
        send_item(KIND_SECOND, 8'hAA);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_SECOND, 8'h7F);
        send_item(KIND_SECOND, 8'h80);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_FIRST, 8'h01);
        send_item(KIND_FINISH, 8'h00);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       configure('0, PCT_W'(100));
                1:       configure(CNT_W'(3), PCT_W'(50));
                2:       configure(CNT_W'(MAX_LEN), PCT_W'(255));
                7:       configure(CNT_W'($urandom_range(0, MAX_LEN)),
                                   PCT_W'($urandom_range(0, 255)));
                default: configure(CNT_W'($urandom_range(0, 6)),
                                   PCT_W'($urandom_range(0, 100)));
            endcase
            if (phase == 0) begin
                // receiver holds off long enough for results to back up into the input
                hold_requests <= hold_requests + 1;
                idle_on = 1'b0;
                repeat (3) send_sequence(short_len(), short_len(), 4, 1'b0);
            end
            phase_items = items_sent;
            phase_done  = finishes;
            while (items_sent - phase_items < 30 || finishes - phase_done < 2)
                random_sequence();
        end

        wait_drained();
        repeat (LATENCY) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
